// ----- hw/rtl/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg: shared constants and types of the record merge sorter
// record layout, store sizing and the sequencer state codes
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

    // store capacity and name length in characters
    localparam int MAX_RECORDS = 32;
    localparam int NAME_CHARS  = 8;

    // field widths of one record
    localparam int KEY_W   = 64;
    localparam int ID_W    = 31;
    localparam int SCORE_W = 9;

    // the name keeps every character of the key
    localparam int NAME_BITS = 8 * NAME_CHARS;

    // stream word sizing, first field in the lowest bits, padded to bytes
    localparam int FIELDS_W = KEY_W + ID_W + SCORE_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    // store address, record count and run bound widths
    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int RUN_W  = CNT_W + 2;

    // one stored record
    typedef struct packed {
        logic [NAME_BITS-1:0] name;
        logic [ID_W-1:0]      id;
        logic [SCORE_W-1:0]   score;
    } t_rec;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_START = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/record_merge_sort.sv -----
// ----------------------------------------------------------------------------
// record_merge_sort: buffered merge sort of score records
// loads a set of records, sorts by score descending then name ascending,
// streams the sorted set back out
// ----------------------------------------------------------------------------
// usage
//   slave channel: one record per word; tlast marks the final record of a set
//   master channel: the sorted set, tlast on its final word, tuser set on every
//     word of a set that lost records because the store was full
//   records with equal score and equal name come out newest first
// timing, for a set of n records
//   load: the slave side is ready only while loading
//   sort: bottom-up merge over two record banks in ceil(log2 n) passes; a start
//     state opens each pass and comes again before output; each merge step is
//     one compare of the two run heads read from the source bank's two read
//     ports
//   emit: one word per cycle while the receiver takes them
// stalls: a stalled receiver holds the output register and the emit index;
//   the next set is loaded while the final word still waits to be taken
// reset: synchronous, active low, empties the store and the output register;
//   the record banks are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module record_merge_sort
    import rms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave side
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [TDATA_W-1:0] i_s_tdata,   // name_key, id_value, score
    input  wire logic               i_s_tlast,   // last_record
    // master side
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [TDATA_W-1:0]      o_m_tdata,   // out_name_key, out_id, out_score
    output logic                    o_m_tlast,   // out_last
    output logic                    o_m_tuser    // overflow
);

    // ------------------------------------------------------------------
    // record banks, one write port and two read ports each
    // ------------------------------------------------------------------
    t_rec mem0 [MAX_RECORDS];
    t_rec mem1 [MAX_RECORDS];

    t_rec r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;

    logic              we0, we1;
    logic [ADDR_W-1:0] waddr;
    t_rec              wdata;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic             r_src, n_src;     // bank that holds the current runs
    logic [RUN_W-1:0] r_w, n_w;         // run width of the current pass
    logic [RUN_W-1:0] r_i, n_i;         // left head, also the emit index
    logic [RUN_W-1:0] r_j, n_j;         // right head
    logic [RUN_W-1:0] r_k, n_k;         // write position
    logic [RUN_W-1:0] r_mid, n_mid;     // end of left run
    logic [RUN_W-1:0] r_hi, n_hi;       // end of right run

    // output register
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_out_last;
    logic               r_out_ovf;

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic             s_fire;
    logic             out_free;
    logic             load_out;
    logic             emit_last;
    logic             take_left;
    t_rec             in_rec;
    t_rec             rd_a, rd_b;
    logic [RUN_W-1:0] cnt_run;
    logic [RUN_W-1:0] init_lo, init_mid, init_hi;
    logic [RUN_W-1:0] sum_mid, sum_hi;

    // strict ordering: higher score first, then smaller name
    function automatic logic goes_first(input t_rec a, input t_rec b);
        logic res;
        if (a.score != b.score) begin
            res = (a.score > b.score);
        end else begin
            res = (a.name < b.name);
        end
        return res;
    endfunction

    assign o_s_tready = (r_state == S_LOAD);
    assign s_fire     = i_s_tvalid && o_s_tready;

    assign in_rec.name  = i_s_tdata[NAME_BITS-1:0];
    assign in_rec.id    = i_s_tdata[KEY_W +: ID_W];
    assign in_rec.score = i_s_tdata[KEY_W+ID_W +: SCORE_W];

    // read data belongs to the heads held in r_i and r_j
    assign rd_a = r_src ? r_rd1_a : r_rd0_a;
    assign rd_b = r_src ? r_rd1_b : r_rd0_b;

    assign cnt_run = RUN_W'(r_count);

    // next pair of runs starts at zero on a new pass, else after the last pair
    assign init_lo  = (r_state == S_START) ? '0 : r_hi;
    assign sum_mid  = init_lo + r_w;
    assign sum_hi   = init_lo + (r_w << 1);
    assign init_mid = (sum_mid < cnt_run) ? sum_mid : cnt_run;
    assign init_hi  = (sum_hi < cnt_run) ? sum_hi : cnt_run;

    // take the right head on a full tie, the left one only when strictly first or the right run is used up
    assign take_left = (r_i < r_mid) && (!(r_j < r_hi) || goes_first(rd_a, rd_b));

    assign out_free  = !r_out_valid || i_m_tready;
    assign load_out  = (r_state == S_EMIT) && out_free;
    assign emit_last = ((r_i + RUN_W'(1)) == cnt_run);

    // reads follow the next heads so the registered data lines up with the registered heads
    assign rd_addr_a = n_i[ADDR_W-1:0];
    assign rd_addr_b = n_j[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_src   = r_src;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        we0     = 1'b0;
        we1     = 1'b0;
        waddr   = r_k[ADDR_W-1:0];
        wdata   = take_left ? rd_a : rd_b;

        case (r_state)
            S_LOAD: begin
                if (s_fire) begin
                    if (r_count < CNT_W'(MAX_RECORDS)) begin
                        we0     = 1'b1;
                        waddr   = r_count[ADDR_W-1:0];
                        wdata   = in_rec;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = S_START;
                        n_w     = RUN_W'(1);
                        n_src   = 1'b0;
                    end
                end
            end
            S_START: begin
                // bubble cycle keeps reads clear of the write just done
                if (r_w >= cnt_run) begin
                    n_state = S_EMIT;
                    n_i     = '0;
                end else begin
                    n_state = S_MERGE;
                    n_i     = init_lo;
                    n_j     = init_mid;
                    n_k     = init_lo;
                    n_mid   = init_mid;
                    n_hi    = init_hi;
                end
            end
            S_MERGE: begin
                we0 = r_src;
                we1 = !r_src;
                if (take_left) begin
                    n_i = r_i + RUN_W'(1);
                end else begin
                    n_j = r_j + RUN_W'(1);
                end
                n_k = r_k + RUN_W'(1);
                if ((r_k + RUN_W'(1)) == r_hi) begin
                    if (r_hi == cnt_run) begin
                        // pass complete, runs double and banks swap
                        n_state = S_START;
                        n_w     = r_w << 1;
                        n_src   = !r_src;
                    end else begin
                        n_i   = init_lo;
                        n_j   = init_mid;
                        n_k   = init_lo;
                        n_mid = init_mid;
                        n_hi  = init_hi;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_i = r_i + RUN_W'(1);
                    if (emit_last) begin
                        n_state = S_LOAD;
                        n_count = '0;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_w   <= n_w;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
    end

    // ------------------------------------------------------------------
    // record banks
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[waddr] <= wdata;
        end
        r_rd0_a <= mem0[rd_addr_a];
        r_rd0_b <= mem0[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[waddr] <= wdata;
        end
        r_rd1_a <= mem1[rd_addr_a];
        r_rd1_b <= mem1[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= TDATA_W'({rd_a.score, rd_a.id, KEY_W'(rd_a.name)});
            r_out_last <= emit_last;
            r_out_ovf  <= r_drop;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_merge_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |->
            (r_i <= r_mid) && (r_j <= r_hi) && (r_k < r_hi) &&
            (r_k == r_i + r_j - r_mid))
        else $error("merge heads out of step with write position");

    a_emit_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_w >= cnt_run) && (r_i < cnt_run))
        else $error("emit before sort completes or past the set");

    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && emit_last) |=>
            (r_state == S_LOAD) && (r_count == '0) && !r_drop && o_m_tlast)
        else $error("set not closed after final word");

endmodule

`default_nettype wire

// ----- tb/sorted_stream_check.sv -----
// ----------------------------------------------------------------------------
// sorted_stream_check: scoreboard for the record merge sorter
// watches both stream channels, keeps its own copy of the record store,
// ranks each finished set and compares every sorted word field by field
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_stream_check
    import rms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave side of the block, observed only
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [TDATA_W-1:0] i_s_tdata,   // name_key, id_value, score
    input  wire logic               i_s_tlast,   // last_record
    // master side of the block, observed only
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [TDATA_W-1:0] i_m_tdata,   // out_name_key, out_id, out_score
    input  wire logic               i_m_tlast,   // out_last
    input  wire logic               i_m_tuser,   // overflow
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);

    localparam int ID_LSB    = KEY_W;
    localparam int SCORE_LSB = KEY_W + ID_W;

    typedef struct packed {
        t_rec rec;
        logic last;
        logic dropped;
    } t_sorted_word;

    t_rec         set_recs[$];     // records of the set being loaded, arrival order
    t_rec         ranked[$];
    bit           set_dropped;
    t_sorted_word sorted_q[$];     // words still owed by the block
    t_sorted_word want;
    t_rec         rec_in;
    int           pos;
    int           fails   = 0;
    int           checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    task automatic report_field(input string field, input logic [KEY_W-1:0] exp_val,
                                input logic [KEY_W-1:0] act_val);
        $display("%0t %s: expected %h, got %h", $time, field, exp_val, act_val);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_recs.delete();
            sorted_q.delete();
            set_dropped = 1'b0;
            o_pending <= 0;
        end else begin
            // output side first: a word taken now belongs to an earlier set
            if (i_m_tvalid && i_m_tready) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, got %h last %b ovf %b",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                    fails++;
                end else begin
                    want = sorted_q.pop_front();
                    checked++;
                    if (i_m_tdata[KEY_W-1:0] !== KEY_W'(want.rec.name))
                        report_field("name key", KEY_W'(want.rec.name), i_m_tdata[KEY_W-1:0]);
                    if (i_m_tdata[ID_LSB +: ID_W] !== want.rec.id)
                        report_field("id", KEY_W'(want.rec.id),
                                     KEY_W'(i_m_tdata[ID_LSB +: ID_W]));
                    if (i_m_tdata[SCORE_LSB +: SCORE_W] !== want.rec.score)
                        report_field("score", KEY_W'(want.rec.score),
                                     KEY_W'(i_m_tdata[SCORE_LSB +: SCORE_W]));
                    if (i_m_tlast !== want.last)
                        report_field("last", KEY_W'(want.last), KEY_W'(i_m_tlast));
                    if (i_m_tuser !== want.dropped)
                        report_field("overflow", KEY_W'(want.dropped), KEY_W'(i_m_tuser));
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                rec_in.name  = i_s_tdata[NAME_BITS-1:0];
                rec_in.id    = i_s_tdata[ID_LSB +: ID_W];
                rec_in.score = i_s_tdata[SCORE_LSB +: SCORE_W];
                // a full store drops the record but still honours its last mark
                if (set_recs.size() < MAX_RECORDS)
                    set_recs.insert(set_recs.size(), rec_in);
                else
                    set_dropped = 1'b1;

                if (i_s_tlast) begin
                    // insert in arrival order; a newcomer goes ahead of every
                    // record that does not strictly beat it, so full ties end
                    // up newest first as the merges leave them
                    ranked.delete();
                    foreach (set_recs[i]) begin
                        pos = 0;
                        while (pos < ranked.size() &&
                               (ranked[pos].score > set_recs[i].score ||
                                (ranked[pos].score == set_recs[i].score &&
                                 ranked[pos].name < set_recs[i].name)))
                            pos++;
                        ranked.insert(pos, set_recs[i]);
                    end
                    foreach (ranked[k]) begin
                        want.rec     = ranked[k];
                        want.last    = (k == ranked.size() - 1);
                        want.dropped = set_dropped;
                        sorted_q.insert(sorted_q.size(), want);
                    end
                    set_recs.delete();
                    set_dropped = 1'b0;
                end
            end

            o_pending <= sorted_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stream-level test of the record merge sorter
// feeds record sets of many sizes, including sets over capacity and sets rich
// in ties, under several idle and stall mixes; a scoreboard checks the order
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import rms_pkg::*;

    // receiver hold-off used to fill the block and back up its input
    localparam int HOLD_CYCLES = 600;
    // records per random phase
    localparam int PHASE_RECORDS = 80;

    typedef enum int {
        MIX_WIDE,   // fields spread over their whole range
        MIX_TIED    // few names and scores, so ties and full ties are common
    } t_set_mix;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata  = '0;    // name_key, id_value, score
    logic               i_s_tlast  = 1'b0;  // last_record
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;          // out_name_key, out_id, out_score
    logic               o_m_tlast;          // out_last
    logic               o_m_tuser;          // overflow

    int fail_count;
    int words_pending;
    int words_checked;

    // sender idle chance, only used by the stimulus process
    int send_idle_pct = 0;
    // receiver stall chance, read by the receiver process
    int stall_pct     = 0;
    // toggled to ask the receiver for a long hold-off
    bit hold_token    = 1'b0;
    bit hold_seen     = 1'b0;
    int hold_left     = 0;

    int records_sent   = 0;
    int sets_sent      = 0;
    int overflow_sets  = 0;
    int words_in_set   = 0;

    always #5 i_clk = ~i_clk;

    record_merge_sort dut (.*);

    sorted_stream_check scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (words_pending),
        .o_checked    (words_checked)
    );

    // receiver: random stalls, or a counted hold-off when asked for one
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one record word, preceded by random idle cycles; returns once taken
    task automatic send_word(input logic [KEY_W-1:0] name, input logic [ID_W-1:0] id,
                             input logic [SCORE_W-1:0] score, input bit last);
        logic [TDATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        word[KEY_W-1:0]             = name;
        word[KEY_W +: ID_W]         = id;
        word[KEY_W + ID_W +: SCORE_W] = score;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        records_sent++;
        words_in_set++;
        if (last) begin
            sets_sent++;
            if (words_in_set > MAX_RECORDS)
                overflow_sets++;
            words_in_set = 0;
        end
    endtask

    // a whole set with random content, last mark on its final record
    task automatic send_set(input int count, input t_set_mix mix);
        logic [KEY_W-1:0]   name_pool [3];
        logic [SCORE_W-1:0] score_pool [3];
        logic [KEY_W-1:0]   name;
        logic [SCORE_W-1:0] score;
        for (int p = 0; p < 3; p++) begin
            name_pool[p]  = {$urandom, $urandom};
            score_pool[p] = SCORE_W'($urandom_range(0, 511));
        end
        for (int k = 0; k < count; k++) begin
            if (mix == MIX_TIED) begin
                name  = name_pool[$urandom_range(2)];
                score = score_pool[$urandom_range(2)];
            end else begin
                name  = {$urandom, $urandom};
                // scores above 400 are legal bit patterns, kept less common
                score = ($urandom_range(99) < 80) ? SCORE_W'($urandom_range(0, 400))
                                                  : SCORE_W'($urandom_range(0, 511));
            end
            send_word(name, ID_W'($urandom), score, k == count - 1);
        end
    endtask

    // stop offering words until every owed sorted word has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (words_pending != 0);
    endtask

    initial begin
        int phase_start;
        int r;
        int count;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sets, no idling
        // single record at the top of every field, then one all zero
        send_word('1, 31'h7FFF_FFFF, 9'd511, 1'b1);
        send_word('0, '0, '0, 1'b1);
        // full ties on score and name: must come out newest first
        for (int k = 0; k < 4; k++)
            send_word(64'h414C_4943_4500_0000, 31'(k + 1), 9'd400, k == 3);
        // mixed scores, name tie-breaks, unsigned compare on the key top bit
        send_word(64'h424F_4200_0000_0000, 31'd10, 9'd400, 1'b0);   // BOB
        send_word(64'h414C_4943_4500_0000, 31'd11, 9'd400, 1'b0);   // ALICE
        send_word(64'h414C_4943_4500_0000, 31'd12, 9'd399, 1'b0);
        send_word(64'h8000_0000_0000_0000, 31'd13, 9'd0,   1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 31'd14, 9'd0,   1'b0);
        send_word(64'h424F_4200_0000_0000, 31'd15, 9'd511, 1'b0);
        send_word(64'h0000_0000_0000_0000, 31'd16, 9'd256, 1'b0);
        send_word(64'h414C_4943_4500_0000, 31'd17, 9'd400, 1'b1);   // full tie with 11
        // two records, second one ranks first
        send_word(64'h5A00_0000_0000_0000, 31'd20, 9'd1, 1'b0);
        send_word(64'h4100_0000_0000_0000, 31'd21, 9'd2, 1'b1);
        wait_drained();

        // long receiver hold-off: an over-full set whose last mark falls on a
        // dropped record, then a second set that has to wait at the input
        hold_token <= ~hold_token;
        send_set(36, MIX_TIED);
        send_set(5, MIX_WIDE);
        wait_drained();

        // random phases with different idle mixes, drained between phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    send_idle_pct = 84;
                    stall_pct    <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct    <= 84;
                end
                default: begin
                    send_idle_pct = 19;
                    stall_pct    <= 19;
                end
            endcase
            phase_start = records_sent;
            while (records_sent - phase_start < PHASE_RECORDS) begin
                // mostly small sets, some up to capacity, a few over it
                r = $urandom_range(99);
                if (r < 65)
                    count = $urandom_range(1, 8);
                else if (r < 90)
                    count = $urandom_range(9, MAX_RECORDS);
                else
                    count = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 8);
                send_set(count, ($urandom_range(1) != 0) ? MIX_TIED : MIX_WIDE);
            end
            wait_drained();
        end

        // let any stray word show up before the verdict
        repeat (60) @(posedge i_clk);

        $display("run: %0d records in %0d sets, %0d over capacity; %0d sorted words compared",
                 records_sent, sets_sent, overflow_sets, words_checked);
        $display("idle mixes: none, sender 84%%, receiver 84%%, both 19%%, %s %0d cycles",
                 "plus a hold-off of", HOLD_CYCLES);
        if (fail_count == 0 && words_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d words still owed", words_pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
